// ----- rtl/i2cm_pkg.sv -----
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Shared types, command codes, reset values and a helper for the bit engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int HoldWidth = 16;

    localparam logic [1:0] OpStart = 2'd0;
    localparam logic [1:0] OpStop  = 2'd1;
    localparam logic [1:0] OpWrite = 2'd2;
    localparam logic [1:0] OpRead  = 2'd3;

    localparam logic       CfgLongHold  = 1'b0;
    localparam logic       CfgShortHold = 1'b1;

    localparam logic [HoldWidth-1:0] LongHoldReset  = HoldWidth'(500);
    localparam logic [HoldWidth-1:0] ShortHoldReset = HoldWidth'(200);

    localparam logic [3:0] BitsPerByte = 4'd8;

    typedef enum logic [12:0] {
        PH_IDLE  = 13'b0000000000001,
        PH_ST_A  = 13'b0000000000010,
        PH_ST_B  = 13'b0000000000100,
        PH_SP_A  = 13'b0000000001000,
        PH_SP_B  = 13'b0000000010000,
        PH_WR_LO = 13'b0000000100000,
        PH_WR_HI = 13'b0000001000000,
        PH_WA_LO = 13'b0000010000000,
        PH_WA_HI = 13'b0000100000000,
        PH_RD_HI = 13'b0001000000000,
        PH_RD_LO = 13'b0010000000000,
        PH_AK_LO = 13'b0100000000000,
        PH_AK_HI = 13'b1000000000000
    } t_phase;

    // One classified tick as the engine sees it.
    typedef struct packed {
        logic       is_start;
        logic       is_stop;
        logic       is_write;
        logic       is_read;
        logic [7:0] tx_byte;
        logic       send_nack;
        logic       sda_in;
    } t_item;

    // Line levels and status after one tick.
    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_received;
    } t_res;

    // A hold count of zero behaves as a single tick.
    function automatic logic [HoldWidth-1:0] hold_of(input logic [HoldWidth-1:0] value);
        hold_of = (value == '0) ? HoldWidth'(1) : value;
    endfunction

endpackage

// ----- rtl/i2c_master_bit_engine_core.sv -----
// A pushed tick is registered in the input queue, then its result in the result queue.
// Throughput: one tick per cycle while pop keeps up; the engine advances only on executed ticks.
// Two-entry queues sit at the input and the output, so either side may stall alone.
// Reset (synchronous, active low) empties both queues, restores the hold
// registers to 500 and 200 ticks and returns the engine to idle with SCL, SDA high.
// ----------------------------------------------------------------------------
// I2C master bit engine top level
// Input queue with command decode, phase sequencer and result queue.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_idx,
    input  logic [i2cm_pkg::HoldWidth-1:0] i_cfg_wdata,
    input  logic                           push,
    output logic                           full,
    input  logic                           i_cmd_valid,
    input  logic [1:0]                     i_op,
    input  logic [7:0]                     i_tx_byte,
    input  logic                           i_send_nack,
    input  logic                           i_sda_in,
    output logic                           empty,
    input  logic                           pop,
    output logic                           o_scl_out,
    output logic                           o_sda_out,
    output logic                           o_sda_drive,
    output logic                           o_busy_res,
    output logic                           o_done_res,
    output logic [7:0]                     o_rx_byte,
    output logic                           o_ack_received
);

    i2cm_pkg::t_item w_item;
    i2cm_pkg::t_res  w_eng_res;
    i2cm_pkg::t_res  w_out_res;
    logic            w_item_valid;
    logic            w_res_full;
    logic            w_fire;

    // A tick is executed when one is queued and the result queue has room.
    assign w_fire = w_item_valid && !w_res_full;

    i2cm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_cmd_valid  (i_cmd_valid),
        .i_op         (i_op),
        .i_tx_byte    (i_tx_byte),
        .i_send_nack  (i_send_nack),
        .i_sda_in     (i_sda_in),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_item_take  (w_fire)
    );

    i2cm_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (w_fire),
        .i_item      (w_item),
        .o_res       (w_eng_res)
    );

    i2cm_resq u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_fire),
        .i_res   (w_eng_res),
        .o_full  (w_res_full),
        .empty   (empty),
        .pop     (pop),
        .o_res   (w_out_res)
    );

    assign o_scl_out      = w_out_res.scl_out;
    assign o_sda_out      = w_out_res.sda_out;
    assign o_sda_drive    = w_out_res.sda_drive;
    assign o_busy_res     = w_out_res.busy_res;
    assign o_done_res     = w_out_res.done_res;
    assign o_rx_byte      = w_out_res.rx_byte;
    assign o_ack_received = w_out_res.ack_received;

endmodule

// ----- rtl/i2cm_front.sv -----
// ----------------------------------------------------------------------------
// I2C master bit engine front end
// Accepts ticks, decodes the command into one-hot class flags (all clear without a command) and queues them.
// ----------------------------------------------------------------------------
module i2cm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic              i_cmd_valid,
    input  logic [1:0]        i_op,
    input  logic [7:0]        i_tx_byte,
    input  logic              i_send_nack,
    input  logic              i_sda_in,
    output logic              o_item_valid,
    output i2cm_pkg::t_item   o_item,
    input  logic              i_item_take
);

    i2cm_pkg::t_item r_mem [2];
    i2cm_pkg::t_item w_item;
    logic            r_wptr, n_wptr;
    logic            r_rptr, n_rptr;
    logic [1:0]      r_cnt, n_cnt;
    logic            w_wr;
    logic            w_rd;

    always_comb begin
        w_item.is_start  = i_cmd_valid && (i_op == i2cm_pkg::OpStart);
        w_item.is_stop   = i_cmd_valid && (i_op == i2cm_pkg::OpStop);
        w_item.is_write  = i_cmd_valid && (i_op == i2cm_pkg::OpWrite);
        w_item.is_read   = i_cmd_valid && (i_op == i2cm_pkg::OpRead);
        w_item.tx_byte   = i_tx_byte;
        w_item.send_nack = i_send_nack;
        w_item.sda_in    = i_sda_in;
    end

    assign full         = (r_cnt == 2'd2);
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_mem[r_rptr];
    assign w_wr         = push && !full;
    assign w_rd         = i_item_take && o_item_valid;

    always_comb begin
        n_wptr = w_wr ? !r_wptr : r_wptr;
        n_rptr = w_rd ? !r_rptr : r_rptr;
        n_cnt  = r_cnt + 2'(w_wr) - 2'(w_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= w_item;
        end
    end

endmodule

// ----- rtl/i2cm_engine.sv -----
// ----------------------------------------------------------------------------
// I2C master bit engine core sequencer
// Runs the phase sequence of start, stop, write and read, stepping once per executed tick.
// ----------------------------------------------------------------------------
module i2cm_engine (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_idx,
    input  logic [i2cm_pkg::HoldWidth-1:0]    i_cfg_wdata,
    input  logic                              i_fire,
    input  i2cm_pkg::t_item                   i_item,
    output i2cm_pkg::t_res                    o_res
);

    logic [i2cm_pkg::HoldWidth-1:0] r_long_hold;
    logic [i2cm_pkg::HoldWidth-1:0] r_short_hold;
    logic [i2cm_pkg::HoldWidth-1:0] w_long;
    logic [i2cm_pkg::HoldWidth-1:0] w_short;
    logic [i2cm_pkg::HoldWidth-1:0] w_dec;

    i2cm_pkg::t_phase               r_phase, n_phase;
    logic [7:0]                     r_shift, n_shift;
    logic [3:0]                     r_bit_cnt, n_bit_cnt;
    logic [i2cm_pkg::HoldWidth-1:0] r_hold, n_hold;
    logic                           r_scl, n_scl;
    logic                           r_sda, n_sda;
    logic                           r_en, n_en;
    logic                           r_nack, n_nack;
    logic                           r_ack, n_ack;
    logic [7:0]                     r_rx, n_rx;
    logic                           n_done;

    assign w_long  = i2cm_pkg::hold_of(r_long_hold);
    assign w_short = i2cm_pkg::hold_of(r_short_hold);
    assign w_dec   = (r_hold != '0) ? r_hold - i2cm_pkg::HoldWidth'(1) : '0;

    always_comb begin
        n_phase   = r_phase;
        n_shift   = r_shift;
        n_bit_cnt = r_bit_cnt;
        n_hold    = r_hold;
        n_scl     = r_scl;
        n_sda     = r_sda;
        n_en      = r_en;
        n_nack    = r_nack;
        n_ack     = r_ack;
        n_rx      = r_rx;
        n_done    = 1'b0;

        if (r_phase == i2cm_pkg::PH_IDLE) begin
            if (i_item.is_start) begin
                n_en = 1'b1; n_sda = 1'b1; n_scl = 1'b1;
                n_phase = i2cm_pkg::PH_ST_A; n_hold = w_long;
            end else if (i_item.is_stop) begin
                n_en = 1'b1; n_sda = 1'b0; n_scl = 1'b1;
                n_phase = i2cm_pkg::PH_SP_A; n_hold = w_long;
            end else if (i_item.is_write) begin
                n_shift = i_item.tx_byte;
                n_bit_cnt = 4'd0;
                n_en = 1'b1; n_scl = 1'b0; n_sda = i_item.tx_byte[7];
                n_phase = i2cm_pkg::PH_WR_LO; n_hold = w_short;
            end else if (i_item.is_read) begin
                n_shift = 8'd0;
                n_bit_cnt = 4'd0;
                n_nack = i_item.send_nack;
                n_en = 1'b0; n_scl = 1'b1;
                n_phase = i2cm_pkg::PH_RD_HI; n_hold = w_short;
            end
        end else begin
            n_hold = w_dec;
            if (w_dec == '0) begin
                unique case (r_phase)
                    i2cm_pkg::PH_ST_A: begin
                        n_sda = 1'b0; n_phase = i2cm_pkg::PH_ST_B; n_hold = w_long;
                    end
                    i2cm_pkg::PH_ST_B: begin
                        n_scl = 1'b0; n_phase = i2cm_pkg::PH_IDLE; n_done = 1'b1;
                    end
                    i2cm_pkg::PH_SP_A: begin
                        n_sda = 1'b1; n_phase = i2cm_pkg::PH_SP_B; n_hold = w_long;
                    end
                    i2cm_pkg::PH_SP_B: begin
                        n_phase = i2cm_pkg::PH_IDLE; n_done = 1'b1;
                    end
                    i2cm_pkg::PH_WR_LO: begin
                        n_scl = 1'b1; n_phase = i2cm_pkg::PH_WR_HI; n_hold = w_short;
                    end
                    i2cm_pkg::PH_WR_HI: begin
                        n_scl     = 1'b0;
                        n_shift   = {r_shift[6:0], 1'b0};
                        n_bit_cnt = r_bit_cnt + 4'd1;
                        n_hold    = w_short;
                        if (n_bit_cnt >= i2cm_pkg::BitsPerByte) begin
                            n_en    = 1'b0;
                            n_phase = i2cm_pkg::PH_WA_LO;
                        end else begin
                            n_sda   = r_shift[6];
                            n_phase = i2cm_pkg::PH_WR_LO;
                        end
                    end
                    i2cm_pkg::PH_WA_LO: begin
                        n_scl = 1'b1; n_phase = i2cm_pkg::PH_WA_HI; n_hold = w_long;
                    end
                    i2cm_pkg::PH_WA_HI: begin
                        // A low SDA at the end of the acknowledge clock, after the eight data bits, is the slave's ACK.
                        n_ack = !i_item.sda_in;
                        n_scl = 1'b0; n_en = 1'b1;
                        n_phase = i2cm_pkg::PH_IDLE; n_done = 1'b1;
                    end
                    i2cm_pkg::PH_RD_HI: begin
                        n_shift = {r_shift[6:0], i_item.sda_in};
                        n_scl = 1'b0; n_phase = i2cm_pkg::PH_RD_LO; n_hold = w_short;
                    end
                    i2cm_pkg::PH_RD_LO: begin
                        n_bit_cnt = r_bit_cnt + 4'd1;
                        if (n_bit_cnt >= i2cm_pkg::BitsPerByte) begin
                            n_en = 1'b1; n_sda = r_nack;
                            n_phase = i2cm_pkg::PH_AK_LO; n_hold = w_long;
                        end else begin
                            n_scl = 1'b1;
                            n_phase = i2cm_pkg::PH_RD_HI; n_hold = w_short;
                        end
                    end
                    i2cm_pkg::PH_AK_LO: begin
                        n_scl = 1'b1; n_phase = i2cm_pkg::PH_AK_HI; n_hold = w_long;
                    end
                    i2cm_pkg::PH_AK_HI: begin
                        n_scl = 1'b0; n_rx = r_shift;
                        n_phase = i2cm_pkg::PH_IDLE; n_done = 1'b1;
                    end
                    default: begin
                        n_phase = i2cm_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_res.scl_out      = n_scl;
        o_res.sda_out      = n_sda;
        o_res.sda_drive    = n_en;
        o_res.busy_res     = (n_phase != i2cm_pkg::PH_IDLE);
        o_res.done_res     = n_done;
        o_res.rx_byte      = n_rx;
        o_res.ack_received = n_ack;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_hold  <= i2cm_pkg::LongHoldReset;
            r_short_hold <= i2cm_pkg::ShortHoldReset;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == i2cm_pkg::CfgLongHold) begin
                r_long_hold <= i_cfg_wdata;
            end else begin
                r_short_hold <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= i2cm_pkg::PH_IDLE;
            r_shift   <= 8'd0;
            r_bit_cnt <= 4'd0;
            r_hold    <= '0;
            r_scl     <= 1'b1;
            r_sda     <= 1'b1;
            r_en      <= 1'b1;
            r_nack    <= 1'b0;
            r_ack     <= 1'b0;
            r_rx      <= 8'd0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_shift   <= n_shift;
            r_bit_cnt <= n_bit_cnt;
            r_hold    <= n_hold;
            r_scl     <= n_scl;
            r_sda     <= n_sda;
            r_en      <= n_en;
            r_nack    <= n_nack;
            r_ack     <= n_ack;
            r_rx      <= n_rx;
        end
    end

endmodule

// ----- rtl/i2cm_resq.sv -----
// ----------------------------------------------------------------------------
// I2C master bit engine result queue
// Two-entry queue that holds tick results until the consumer takes them.
// ----------------------------------------------------------------------------
module i2cm_resq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  i2cm_pkg::t_res  i_res,
    output logic            o_full,
    output logic            empty,
    input  logic            pop,
    output i2cm_pkg::t_res  o_res
);

    i2cm_pkg::t_res r_mem [2];
    logic           r_wptr, n_wptr;
    logic           r_rptr, n_rptr;
    logic [1:0]     r_cnt, n_cnt;
    logic           w_rd;

    assign o_full = (r_cnt == 2'd2);
    assign empty  = (r_cnt == 2'd0);
    assign o_res  = r_mem[r_rptr];
    assign w_rd   = pop && !empty;

    always_comb begin
        n_wptr = i_wr ? !r_wptr : r_wptr;
        n_rptr = w_rd ? !r_rptr : r_rptr;
        n_cnt  = r_cnt + 2'(i_wr) - 2'(w_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_res;
        end
    end

endmodule

// ----- tb/i2c_master_bit_engine_core_tb.sv -----
// ----------------------------------------------------------------------------
// I2C master bit engine testbench
// Streams timer ticks into the engine through its input queue and checks every
// per-tick line and status result against a cycle model of the phase sequencer.
// Covers reset and zero hold counts, every command, busy commands and back
// pressure on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module i2c_master_bit_engine_core_tb;

    localparam int QuietLimit      = 5000;
    localparam int LongStallCycles = 60;
    localparam int MaxPrinted      = 40;
    localparam int PhaseTicks      = 60;
    localparam int TailTicks       = 24;

    typedef struct packed {
        logic       cmd_valid;
        logic [1:0] op;
        logic [7:0] tx_byte;
        logic       send_nack;
        logic       sda_in;
    } t_tick;

    typedef enum int {SdaLow, SdaHigh, SdaRandom} t_sda_mode;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_cfg_we    = 1'b0;
    logic                           i_cfg_idx   = i2cm_pkg::CfgLongHold;
    logic [i2cm_pkg::HoldWidth-1:0] i_cfg_wdata = '0;
    logic                           push        = 1'b0;
    logic                           full;
    logic                           i_cmd_valid = 1'b0;
    logic [1:0]                     i_op        = i2cm_pkg::OpStart;
    logic [7:0]                     i_tx_byte   = '0;
    logic                           i_send_nack = 1'b0;
    logic                           i_sda_in    = 1'b1;
    logic                           empty;
    logic                           pop         = 1'b0;
    logic                           o_scl_out;
    logic                           o_sda_out;
    logic                           o_sda_drive;
    logic                           o_busy_res;
    logic                           o_done_res;
    logic [7:0]                     o_rx_byte;
    logic                           o_ack_received;

    i2c_master_bit_engine_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .push           (push),
        .full           (full),
        .i_cmd_valid    (i_cmd_valid),
        .i_op           (i_op),
        .i_tx_byte      (i_tx_byte),
        .i_send_nack    (i_send_nack),
        .i_sda_in       (i_sda_in),
        .empty          (empty),
        .pop            (pop),
        .o_scl_out      (o_scl_out),
        .o_sda_out      (o_sda_out),
        .o_sda_drive    (o_sda_drive),
        .o_busy_res     (o_busy_res),
        .o_done_res     (o_done_res),
        .o_rx_byte      (o_rx_byte),
        .o_ack_received (o_ack_received)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Engine model state, hold registers included.
    i2cm_pkg::t_phase               eng_phase  = i2cm_pkg::PH_IDLE;
    logic [7:0]                     eng_shift  = '0;
    logic [3:0]                     eng_bits   = '0;
    logic [i2cm_pkg::HoldWidth-1:0] eng_hold   = '0;
    logic                           eng_scl    = 1'b1;
    logic                           eng_sda    = 1'b1;
    logic                           eng_sda_en = 1'b1;
    logic                           eng_nack   = 1'b0;
    logic                           eng_ack    = 1'b0;
    logic [7:0]                     eng_rx     = '0;
    logic [i2cm_pkg::HoldWidth-1:0] hold_long  = i2cm_pkg::LongHoldReset;
    logic [i2cm_pkg::HoldWidth-1:0] hold_short = i2cm_pkg::ShortHoldReset;

    t_tick          pending_ticks[$];
    i2cm_pkg::t_res expected_res[$];

    int ops_started[4];
    int ticks_queued;
    int ticks_sent;
    int results_seen;
    int mismatches;
    int full_cycles;
    int quiet_cycles;
    int send_idle_pct;
    int recv_idle_pct;
    int send_gap;
    int recv_gap;
    int stall_left;
    bit long_stall_done;

    task automatic flag_mismatch(input string what, input logic [7:0] got_v,
                                 input logic [7:0] want_v);
        mismatches++;
        if (mismatches <= MaxPrinted)
            $display("[%0t] mismatch on %s at result %0d: got %h, expected %h",
                     $time, what, results_seen, got_v, want_v);
    endtask

    task automatic enter_phase(input i2cm_pkg::t_phase next_phase, input bit use_long);
        logic [i2cm_pkg::HoldWidth-1:0] ticks;
        ticks = use_long ? hold_long : hold_short;
        eng_phase = next_phase;
        eng_hold = ticks;
        // A hold of zero still lasts one tick.
        if (ticks == '0)
            eng_hold = i2cm_pkg::HoldWidth'(1);
    endtask

    // Advances the engine model by one tick and returns the lines it shows after it.
    task automatic predict_bus_tick(input t_tick t, output i2cm_pkg::t_res r);
        logic finished;
        finished = 1'b0;
        if (eng_phase == i2cm_pkg::PH_IDLE) begin
            if (t.cmd_valid) begin
                ops_started[t.op]++;
                case (t.op)
                    i2cm_pkg::OpStart: begin
                        eng_sda_en = 1'b1;
                        eng_sda = 1'b1;
                        eng_scl = 1'b1;
                        enter_phase(i2cm_pkg::PH_ST_A, 1'b1);
                    end
                    i2cm_pkg::OpStop: begin
                        eng_sda_en = 1'b1;
                        eng_sda = 1'b0;
                        eng_scl = 1'b1;
                        enter_phase(i2cm_pkg::PH_SP_A, 1'b1);
                    end
                    i2cm_pkg::OpWrite: begin
                        eng_shift = t.tx_byte;
                        eng_bits = '0;
                        eng_sda_en = 1'b1;
                        eng_scl = 1'b0;
                        eng_sda = t.tx_byte[7];
                        enter_phase(i2cm_pkg::PH_WR_LO, 1'b0);
                    end
                    default: begin
                        eng_shift = '0;
                        eng_bits = '0;
                        eng_nack = t.send_nack;
                        eng_sda_en = 1'b0;
                        eng_scl = 1'b1;
                        enter_phase(i2cm_pkg::PH_RD_HI, 1'b0);
                    end
                endcase
            end
        end else begin
            if (eng_hold != '0)
                eng_hold = eng_hold - i2cm_pkg::HoldWidth'(1);
            if (eng_hold == '0) begin
                case (eng_phase)
                    i2cm_pkg::PH_ST_A: begin
                        eng_sda = 1'b0;
                        enter_phase(i2cm_pkg::PH_ST_B, 1'b1);
                    end
                    i2cm_pkg::PH_ST_B: begin
                        eng_scl = 1'b0;
                        eng_phase = i2cm_pkg::PH_IDLE;
                        finished = 1'b1;
                    end
                    i2cm_pkg::PH_SP_A: begin
                        eng_sda = 1'b1;
                        enter_phase(i2cm_pkg::PH_SP_B, 1'b1);
                    end
                    i2cm_pkg::PH_SP_B: begin
                        eng_phase = i2cm_pkg::PH_IDLE;
                        finished = 1'b1;
                    end
                    i2cm_pkg::PH_WR_LO: begin
                        eng_scl = 1'b1;
                        enter_phase(i2cm_pkg::PH_WR_HI, 1'b0);
                    end
                    i2cm_pkg::PH_WR_HI: begin
                        eng_scl = 1'b0;
                        eng_shift = eng_shift << 1;
                        eng_bits = eng_bits + 4'd1;
                        if (eng_bits >= i2cm_pkg::BitsPerByte) begin
                            // SDA is released for a full low phase before the ack clock.
                            eng_sda_en = 1'b0;
                            enter_phase(i2cm_pkg::PH_WA_LO, 1'b0);
                        end else begin
                            eng_sda = eng_shift[7];
                            enter_phase(i2cm_pkg::PH_WR_LO, 1'b0);
                        end
                    end
                    i2cm_pkg::PH_WA_LO: begin
                        eng_scl = 1'b1;
                        enter_phase(i2cm_pkg::PH_WA_HI, 1'b1);
                    end
                    i2cm_pkg::PH_WA_HI: begin
                        eng_ack = ~t.sda_in;
                        eng_scl = 1'b0;
                        eng_sda_en = 1'b1;
                        eng_phase = i2cm_pkg::PH_IDLE;
                        finished = 1'b1;
                    end
                    i2cm_pkg::PH_RD_HI: begin
                        eng_shift = {eng_shift[6:0], t.sda_in};
                        eng_scl = 1'b0;
                        enter_phase(i2cm_pkg::PH_RD_LO, 1'b0);
                    end
                    i2cm_pkg::PH_RD_LO: begin
                        eng_bits = eng_bits + 4'd1;
                        if (eng_bits >= i2cm_pkg::BitsPerByte) begin
                            eng_sda_en = 1'b1;
                            eng_sda = eng_nack;
                            enter_phase(i2cm_pkg::PH_AK_LO, 1'b1);
                        end else begin
                            eng_scl = 1'b1;
                            enter_phase(i2cm_pkg::PH_RD_HI, 1'b0);
                        end
                    end
                    i2cm_pkg::PH_AK_LO: begin
                        eng_scl = 1'b1;
                        enter_phase(i2cm_pkg::PH_AK_HI, 1'b1);
                    end
                    i2cm_pkg::PH_AK_HI: begin
                        eng_scl = 1'b0;
                        eng_rx = eng_shift;
                        eng_phase = i2cm_pkg::PH_IDLE;
                        finished = 1'b1;
                    end
                    default: eng_phase = i2cm_pkg::PH_IDLE;
                endcase
            end
        end
        r.scl_out = eng_scl;
        r.sda_out = eng_sda;
        r.sda_drive = eng_sda_en;
        r.busy_res = (eng_phase != i2cm_pkg::PH_IDLE);
        r.done_res = finished;
        r.rx_byte = eng_rx;
        r.ack_received = eng_ack;
    endtask

    function automatic t_tick random_tick();
        t_tick t;
        t.cmd_valid = 1'($urandom_range(1));
        t.op = 2'($urandom_range(3));
        t.tx_byte = 8'($urandom_range(255));
        t.send_nack = 1'($urandom_range(1));
        t.sda_in = 1'($urandom_range(1));
        return t;
    endfunction

    // Ticks from the accepting tick through the tick that reports completion.
    function automatic int command_length(input logic [1:0] op);
        int l;
        int s;
        l = (hold_long == '0) ? 1 : int'(hold_long);
        s = (hold_short == '0) ? 1 : int'(hold_short);
        case (op)
            i2cm_pkg::OpStart, i2cm_pkg::OpStop: return 2 * l + 1;
            i2cm_pkg::OpWrite:                   return 17 * s + l + 1;
            default:                             return 16 * s + 2 * l + 1;
        endcase
    endfunction

    // Queues one command and the ticks it runs for. Commands on busy ticks are
    // added at the given percentage and must be ignored by the engine.
    task automatic add_command(input logic [1:0] op, input logic [7:0] data,
                               input logic nack, input t_sda_mode mode,
                               input int stray_pct);
        t_tick t;
        int n;
        n = command_length(op);
        for (int i = 0; i < n; i++) begin
            t = random_tick();
            t.cmd_valid = (i == 0) ? 1'b1 : ($urandom_range(99) < stray_pct);
            if (i == 0) begin
                t.op = op;
                t.tx_byte = data;
                t.send_nack = nack;
            end
            if (mode != SdaRandom)
                t.sda_in = (mode == SdaHigh);
            pending_ticks.push_back(t);
            ticks_queued++;
        end
    endtask

    task automatic add_idle(input int n);
        t_tick t;
        for (int i = 0; i < n; i++) begin
            t = random_tick();
            t.cmd_valid = 1'b0;
            pending_ticks.push_back(t);
            ticks_queued++;
        end
    endtask

    task automatic drain();
        while (pending_ticks.size() != 0 || expected_res.size() != 0)
            @(posedge i_clk);
    endtask

    // Hold registers change only with nothing in flight.
    task automatic set_holds(input logic [i2cm_pkg::HoldWidth-1:0] hold_l,
                             input logic [i2cm_pkg::HoldWidth-1:0] hold_s);
        drain();
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= i2cm_pkg::CfgLongHold;
        i_cfg_wdata <= hold_l;
        @(posedge i_clk);
        i_cfg_idx <= i2cm_pkg::CfgShortHold;
        i_cfg_wdata <= hold_s;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        hold_long = hold_l;
        hold_short = hold_s;
    endtask

    always @(posedge i_clk) begin : tick_driver
        i2cm_pkg::t_res want;
        t_tick          sent;
        logic           offer;
        offer = 1'b0;
        if (i_rst_n) begin
            if (push && full)
                full_cycles++;
            if (push && !full) begin
                sent = {i_cmd_valid, i_op, i_tx_byte, i_send_nack, i_sda_in};
                predict_bus_tick(sent, want);
                expected_res.push_back(want);
                void'(pending_ticks.pop_front());
                ticks_sent++;
            end
            if (send_gap > 0)
                send_gap--;
            else if (pending_ticks.size() != 0) begin
                if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
                    send_gap = $urandom_range(6, 0);
                else
                    offer = 1'b1;
            end
        end
        push <= offer;
        if (offer) begin
            i_cmd_valid <= pending_ticks[0].cmd_valid;
            i_op <= pending_ticks[0].op;
            i_tx_byte <= pending_ticks[0].tx_byte;
            i_send_nack <= pending_ticks[0].send_nack;
            i_sda_in <= pending_ticks[0].sda_in;
        end
    end

    always @(posedge i_clk) begin : result_monitor
        i2cm_pkg::t_res got;
        i2cm_pkg::t_res want;
        logic           take;
        take = 1'b0;
        if (i_rst_n) begin
            if (pop && !empty) begin
                results_seen++;
                got = {o_scl_out, o_sda_out, o_sda_drive, o_busy_res, o_done_res,
                       o_rx_byte, o_ack_received};
                if (expected_res.size() == 0)
                    flag_mismatch("unexpected result", 8'h00, 8'h00);
                else begin
                    want = expected_res.pop_front();
                    if (got.scl_out !== want.scl_out)
                        flag_mismatch("scl_out", 8'(got.scl_out), 8'(want.scl_out));
                    if (got.sda_out !== want.sda_out)
                        flag_mismatch("sda_out", 8'(got.sda_out), 8'(want.sda_out));
                    if (got.sda_drive !== want.sda_drive)
                        flag_mismatch("sda_drive", 8'(got.sda_drive), 8'(want.sda_drive));
                    if (got.busy_res !== want.busy_res)
                        flag_mismatch("busy_res", 8'(got.busy_res), 8'(want.busy_res));
                    if (got.done_res !== want.done_res)
                        flag_mismatch("done_res", 8'(got.done_res), 8'(want.done_res));
                    if (got.rx_byte !== want.rx_byte)
                        flag_mismatch("rx_byte", got.rx_byte, want.rx_byte);
                    if (got.ack_received !== want.ack_received)
                        flag_mismatch("ack_received", 8'(got.ack_received),
                                      8'(want.ack_received));
                end
            end
            // One long hold-off early on lets both queues fill and stall the input.
            if (!long_stall_done && results_seen >= 150) begin
                long_stall_done = 1'b1;
                stall_left = LongStallCycles;
            end
            if (stall_left > 0)
                stall_left--;
            else if (recv_gap > 0)
                recv_gap--;
            else if (recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct)
                recv_gap = $urandom_range(6, 0);
            else
                take = 1'b1;
        end
        pop <= take;
    end

    always @(posedge i_clk) begin : watchdog
        if ((push && !full) || (pop && !empty))
            quiet_cycles = 0;
        else if (quiet_cycles >= QuietLimit) begin
            $display("Watchdog: no transfer for %0d cycles, %0d results still due",
                     quiet_cycles, expected_res.size());
            $display("FAIL i2c_master_bit_engine_core");
            $finish;
        end else
            quiet_cycles++;
    end

    initial begin : stimulus
        logic [i2cm_pkg::HoldWidth-1:0] long_set[6];
        logic [i2cm_pkg::HoldWidth-1:0] short_set[6];
        int    idle_levels[3];
        int    phase_start;
        t_tick first;
        long_set = '{16'd1, 16'd0, 16'd2, 16'd1, 16'd3, 16'd4};
        short_set = '{16'd1, 16'd0, 16'd1, 16'd3, 16'd2, 16'd1};
        idle_levels = '{0, 15, 40};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 20;
        recv_idle_pct = 20;

        // Idle ticks right after reset show the reset line levels.
        add_idle(4);

        // Directed commands with short holds.
        set_holds(16'd2, 16'd1);
        add_command(i2cm_pkg::OpStart, 8'h00, 1'b0, SdaRandom, 0);
        add_command(i2cm_pkg::OpWrite, 8'hFF, 1'b0, SdaLow, 0);
        add_command(i2cm_pkg::OpWrite, 8'h00, 1'b1, SdaHigh, 0);
        add_command(i2cm_pkg::OpRead, 8'h00, 1'b1, SdaHigh, 0);
        add_command(i2cm_pkg::OpRead, 8'hFF, 1'b0, SdaLow, 0);
        add_idle(3);
        add_command(i2cm_pkg::OpWrite, 8'hA5, 1'b0, SdaRandom, 100);
        add_command(i2cm_pkg::OpRead, 8'h5A, 1'b0, SdaRandom, 100);
        add_command(i2cm_pkg::OpStop, 8'hFF, 1'b1, SdaRandom, 0);
        add_idle(2);

        // Random command streams; mostly complete commands, some stray ticks.
        for (int p = 0; p < 6; p++) begin
            set_holds(long_set[p], short_set[p]);
            send_idle_pct = idle_levels[$urandom_range(2)];
            recv_idle_pct = idle_levels[$urandom_range(2)];
            phase_start = ticks_queued;
            while (ticks_queued - phase_start < PhaseTicks) begin
                if ($urandom_range(99) < 85) begin
                    add_command(2'($urandom_range(3)), 8'($urandom_range(255)),
                                1'($urandom_range(1)), SdaRandom, 5);
                    add_idle($urandom_range(2));
                end else begin
                    pending_ticks.push_back(random_tick());
                    ticks_queued++;
                end
            end
        end

        // Final stretch at full rate, ending with the largest hold counts.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_holds(16'd1, 16'd2);
        add_command(i2cm_pkg::OpWrite, 8'($urandom_range(255)), 1'b0, SdaRandom, 0);
        add_command(i2cm_pkg::OpRead, 8'h00, 1'($urandom_range(1)), SdaRandom, 0);
        set_holds(16'hFFFF, 16'hFFFF);
        // Only the opening ticks of a start at the largest hold; it stays busy.
        first = random_tick();
        first.cmd_valid = 1'b1;
        first.op = i2cm_pkg::OpStart;
        pending_ticks.push_back(first);
        ticks_queued++;
        for (int i = 0; i < TailTicks; i++) begin
            pending_ticks.push_back(random_tick());
            ticks_queued++;
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (expected_res.size() != 0)
            flag_mismatch("missing results", 8'(expected_res.size()), 8'h00);
        $display("Ran %0d ticks and checked %0d results; %0d start, %0d stop, %0d write,",
                 ticks_sent, results_seen, ops_started[i2cm_pkg::OpStart],
                 ops_started[i2cm_pkg::OpStop], ops_started[i2cm_pkg::OpWrite]);
        $display("%0d read; holds from zero to 65535, input stalled on %0d cycles.",
                 ops_started[i2cm_pkg::OpRead], full_cycles);
        if (mismatches == 0)
            $display("PASS i2c_master_bit_engine_core");
        else
            $display("FAIL i2c_master_bit_engine_core");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/i2cm_pkg.sv
rtl/i2cm_front.sv
rtl/i2cm_engine.sv
rtl/i2cm_resq.sv
rtl/i2c_master_bit_engine_core.sv
tb/i2c_master_bit_engine_core_tb.sv
